[hdl/salc_pkg.sv]
// Shared constants, types and command structs of the set-associative LRU cache model.
`default_nettype none

package salc_pkg;

  // Geometry of the cache model.
  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_WIDTH   = 32;

  localparam int SET_COUNT = 1 << MAX_SET_BITS;
  localparam int SET_W     = MAX_SET_BITS;
  localparam int WAY_W     = $clog2(MAX_WAYS);
  localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
  localparam int RANK_W    = WAY_W;
  localparam int TAG_W     = ADDR_WIDTH;
  localparam int CNT_W     = 32;

  localparam logic [CNT_W-1:0]  COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [RANK_W-1:0] RANK_MAX  = RANK_W'(MAX_WAYS - 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

  // Access kinds; codes without a name act as a load.
  localparam logic [1:0] ACT_MODIFY = 2'd2;

  // One set of the cache as stored in one memory row.
  typedef struct packed {
    logic [MAX_WAYS-1:0]             valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic capture;
    logic update;
    logic second;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_modify;
  } stat_t;

endpackage

`default_nettype wire

[hdl/salc_ram.sv]
// Generic single-write, single-read memory with a registered read port.
`default_nettype none

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/salc_ctrl.sv]
// Sequencing state machine of the cache model: accept, lookup, update, second hit, result.
`default_nettype none

module salc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output salc_pkg::cmd_t       cmd,
  input  wire salc_pkg::stat_t stat
);

  import salc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE,
    S_SECOND,
    S_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // Commands follow from the state and the handshake inputs.
  always_comb begin
    in_ready     = (state_r == S_IDLE);
    cmd.accept   = in_valid && (state_r == S_IDLE);
    cmd.capture  = (state_r == S_LOOKUP);
    cmd.update   = (state_r == S_UPDATE);
    cmd.second   = (state_r == S_SECOND);
    cmd.load_out = (state_r == S_RESULT) && (!out_valid_r || out_ready);
  end

  // Next state and output valid.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        state_nxt = stat.is_modify ? S_SECOND : S_RESULT;
      end
      S_SECOND: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (cmd.load_out) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[hdl/salc_dp.sv]
// Datapath of the cache model: configuration, set memory, lookup, LRU update and totals.
`default_nettype none

module salc_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [salc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic [1:0]                           in_action,
  input  wire logic [salc_pkg::ADDR_WIDTH-1:0]      in_address,
  input  wire salc_pkg::cmd_t                       cmd,
  output salc_pkg::stat_t                           stat,
  output logic                                      out_was_hit,
  output logic                                      out_was_eviction,
  output logic      [salc_pkg::CNT_W-1:0]           out_hit_total,
  output logic      [salc_pkg::CNT_W-1:0]           out_miss_total,
  output logic      [salc_pkg::CNT_W-1:0]           out_eviction_total
);

  import salc_pkg::*;

  // Configuration registers.
  logic [2:0]        cfg_sets_r;
  logic [4:0]        cfg_off_r;
  logic [WCNT_W-1:0] cfg_ways_r;

  // Access registers.
  logic [TAG_W-1:0]     tag_r;
  logic [SET_W-1:0]     set_r;
  logic                 modify_r;
  logic                 rowok_r;
  logic [SET_COUNT-1:0] row_written_r;

  // Lookup results.
  row_t                row_r;
  logic [MAX_WAYS-1:0] in_use_r;
  logic                hit_r;
  logic                evict_r;
  logic [WAY_W-1:0]    tgt_r;
  logic [WCNT_W-1:0]   limit_r;

  // Running totals.
  logic [CNT_W-1:0] hits_r;
  logic [CNT_W-1:0] misses_r;
  logic [CNT_W-1:0] evicts_r;

  // Address split signals.
  logic [2:0]            sbits_eff;
  logic [ADDR_WIDTH-1:0] blk;
  logic [SET_W-1:0]      set_mask;
  logic [SET_W-1:0]      set_in;
  logic [TAG_W-1:0]      tag_in;

  // Lookup signals.
  logic [ROW_W-1:0]    rdata;
  row_t                row_rd;
  row_t                row_cur;
  logic [WCNT_W-1:0]   ways_eff;
  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] empty_vec;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    empty_way;
  logic [WAY_W-1:0]    vic_way;
  logic [RANK_W-1:0]   best;

  // Update signals.
  row_t row_new;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  // Split the incoming address into set index and tag.
  always_comb begin
    sbits_eff = (cfg_sets_r > 3'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : cfg_sets_r;
    blk       = in_address >> cfg_off_r;
    set_mask  = ~({SET_W{1'b1}} << sbits_eff);
    set_in    = blk[SET_W-1:0] & set_mask;
    tag_in    = TAG_W'(blk >> sbits_eff);
  end

  // Set memory: one row holds valid bits, ranks and tags of all ways of a set.
  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SET_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (set_r),
    .wdata (row_new),
    .re    (cmd.accept),
    .raddr (set_in),
    .rdata (rdata)
  );

  // Search the ways of the set that was read.
  always_comb begin
    row_rd        = row_t'(rdata);
    row_cur       = row_rd;
    row_cur.valid = rowok_r ? row_rd.valid : '0;
    row_cur.rank  = rowok_r ? row_rd.rank : '0;
    if (cfg_ways_r == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (cfg_ways_r > WCNT_W'(MAX_WAYS)) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = cfg_ways_r;
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w]    = WCNT_W'(w) < ways_eff;
      hit_vec[w]   = in_use[w] && row_cur.valid[w] && (row_cur.tag[w] == tag_r);
      empty_vec[w] = in_use[w] && !row_cur.valid[w];
    end
    hit_way   = '0;
    empty_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (empty_vec[w]) begin
        empty_way = WAY_W'(w);
      end
    end
    best    = '0;
    vic_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && (row_cur.rank[w] > best)) begin
        best    = row_cur.rank[w];
        vic_way = WAY_W'(w);
      end
    end
  end

  // Age the lines younger than the limit and install the target line.
  always_comb begin
    row_new = row_r;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use_r[w] && row_r.valid[w] && (WCNT_W'(row_r.rank[w]) < limit_r) &&
          (row_r.rank[w] != RANK_MAX)) begin
        row_new.rank[w] = row_r.rank[w] + RANK_W'(1);
      end
    end
    row_new.valid[tgt_r] = 1'b1;
    row_new.tag[tgt_r]   = tag_r;
    row_new.rank[tgt_r]  = '0;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_sets_r <= '0;
      cfg_off_r  <= '0;
      cfg_ways_r <= WCNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SET_BITS:    cfg_sets_r <= cfg_wdata[2:0];
        CFG_OFFSET_BITS: cfg_off_r  <= cfg_wdata[4:0];
        CFG_WAYS:        cfg_ways_r <= cfg_wdata[WCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Rows that were never written read as empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_written_r <= '0;
    end else if (cmd.update) begin
      row_written_r[set_r] <= 1'b1;
    end
  end

  // Capture the access on its input transfer.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tag_r    <= tag_in;
      set_r    <= set_in;
      modify_r <= (in_action == ACT_MODIFY);
      rowok_r  <= row_written_r[set_in];
    end
  end

  // Register the lookup outcome.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_r    <= row_cur;
      in_use_r <= in_use;
      hit_r    <= |hit_vec;
      evict_r  <= !(|hit_vec) && !(|empty_vec);
      if (|hit_vec) begin
        tgt_r   <= hit_way;
        limit_r <= WCNT_W'(row_cur.rank[hit_way]);
      end else if (|empty_vec) begin
        tgt_r   <= empty_way;
        limit_r <= WCNT_W'(MAX_WAYS);
      end else begin
        tgt_r   <= vic_way;
        limit_r <= WCNT_W'(best);
      end
    end
  end

  // Saturating totals; the second access of a modify always hits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r   <= '0;
      misses_r <= '0;
      evicts_r <= '0;
    end else if (cmd.update) begin
      if (hit_r) begin
        hits_r <= sat_inc(hits_r);
      end else begin
        misses_r <= sat_inc(misses_r);
      end
      if (evict_r) begin
        evicts_r <= sat_inc(evicts_r);
      end
    end else if (cmd.second) begin
      hits_r <= sat_inc(hits_r);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_was_hit        <= hit_r;
      out_was_eviction   <= evict_r;
      out_hit_total      <= hits_r;
      out_miss_total     <= misses_r;
      out_eviction_total <= evicts_r;
    end
  end

  assign stat.is_modify = modify_r;

endmodule

`default_nettype wire

[hdl/set_assoc_lru_cache_sim.sv]
// Top level of the set-associative LRU cache model.
`default_nettype none

// Each access passes from its input transfer through the lookup, update and
// result states; a modify also passes a second-hit state after the update. The
// set's row is read from the single-port-read set memory at the input transfer.
// The lookup state compares tags and picks the hit, empty or victim way, the
// update state writes the updated row back and counts, the second-hit state
// counts the second hit, and the result state loads the output register. Only
// one access is in flight at a time. The next one is taken in the cycle after
// the result is loaded, even while that result still waits for its transfer.
// A result that still waits holds the next access in its load cycle until the
// older one is taken. No clearing pass is needed after reset: a flag per set
// marks rows never written, which read as empty. The user must write
// configuration only while the block is idle; the block does not enforce this.
module set_assoc_lru_cache_sim (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [salc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_action,
  input  wire logic [salc_pkg::ADDR_WIDTH-1:0]   in_address,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_was_hit,
  output logic                                   out_was_eviction,
  output logic      [salc_pkg::CNT_W-1:0]        out_hit_total,
  output logic      [salc_pkg::CNT_W-1:0]        out_miss_total,
  output logic      [salc_pkg::CNT_W-1:0]        out_eviction_total
);

  import salc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Controller.
  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath.
  salc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_action          (in_action),
    .in_address         (in_address),
    .cmd                (cmd),
    .stat               (stat),
    .out_was_hit        (out_was_hit),
    .out_was_eviction   (out_was_eviction),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total),
    .out_eviction_total (out_eviction_total)
  );

`ifndef SYNTH
  // One access at a time: no new transfer right after one was taken.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an access is in flight");

  // The lookup follows the input transfer in the next cycle.
  a_lookup_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> cmd.capture)
    else $error("lookup did not follow the input transfer");

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_was_hit && out_was_eviction))
    else $error("result reports both hit and eviction");

  // The row write-back comes right after the lookup.
  a_update_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.update)
    else $error("row write-back did not follow the lookup");
`endif

endmodule

`default_nettype wire
